// File: design/sac_pkg.sv
// Shared types and constants for the set-associative LRU cache model.
// No dependencies; used by every module of the block.
package sac_pkg;

	localparam int ADDR_W   = 64;
	localparam int CNT_W    = 32;
	localparam int SET_BITS = 10;
	localparam int NUM_SETS = 1 << SET_BITS;
	localparam int MAX_WAYS = 8;
	localparam int WAY_BITS = 3;
	localparam int RANK_W   = 4;
	localparam int CFG_W    = 4;

	localparam logic [CFG_W-1:0] IB_LIMIT = CFG_W'(SET_BITS);
	localparam logic [CFG_W-1:0] WAYS_MAX = CFG_W'(MAX_WAYS);

	localparam logic OP_READ  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef struct packed {
		logic              opcode;
		logic [ADDR_W-1:0] address;
	} in_item_t;

	typedef struct packed {
		logic             hit;
		logic             evicted;
		logic             evicted_dirty;
		logic [CNT_W-1:0] read_count;
		logic [CNT_W-1:0] write_count;
		logic [CNT_W-1:0] read_miss_count;
		logic [CNT_W-1:0] write_miss_count;
		logic [CNT_W-1:0] clean_evict_count;
		logic [CNT_W-1:0] dirty_evict_count;
		logic [CNT_W-1:0] state_checksum;
	} out_item_t;

	typedef struct packed {
		logic [CFG_W-1:0] index_bits;
		logic [CFG_W-1:0] offset_bits;
		logic [CFG_W-1:0] ways_in_use;
	} cfg_t;

	// one classified access waiting for the back end
	typedef struct packed {
		logic                opcode;
		logic [SET_BITS-1:0] set_idx;
		logic [ADDR_W-1:0]   tag;
		logic [CFG_W-1:0]    ways;
	} job_t;

	// front/back handshake on the job queue
	typedef struct packed {
		logic valid;
		job_t job;
	} job_req_t;

	typedef struct packed {
		logic take;
		logic clearing;
	} back_stat_t;

	typedef struct packed {
		logic [MAX_WAYS-1:0]                valid;
		logic [MAX_WAYS-1:0]                dirty;
		logic [MAX_WAYS-1:0][RANK_W-1:0]    rank;
		logic [MAX_WAYS-1:0][ADDR_W-1:0]    tag;
	} row_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

	function automatic logic [CNT_W-1:0] line_sum(input logic [ADDR_W-1:0] tag,
			input logic [SET_BITS-1:0] set_idx, input logic dirty);
		logic [ADDR_W-1:0] x;
		x = tag ^ ADDR_W'(set_idx);
		return {x[CNT_W-2:0], dirty};
	endfunction

endpackage

// File: design/sac_front.sv
// Front end: splits the address into set and tag, clamps the geometry and
// queues the access for the back end. Depends on sac_pkg.
module sac_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  sac_pkg::in_item_t   in_item,
	input  sac_pkg::cfg_t       cfg,
	output sac_pkg::job_req_t   req,
	input  sac_pkg::back_stat_t stat
);

	logic [sac_pkg::CFG_W-1:0]    ib, w;
	logic [sac_pkg::CFG_W:0]      shift_tag;
	logic [sac_pkg::ADDR_W-1:0]   addr_sh;
	logic [sac_pkg::SET_BITS:0]   set_mask;
	sac_pkg::job_t                job_new;
	sac_pkg::job_t                q_q [2];
	logic                         wptr_q, rptr_q;
	logic [1:0]                   cnt_q;
	logic                         acc;

	always_comb begin
		ib = (cfg.index_bits > sac_pkg::IB_LIMIT) ? sac_pkg::IB_LIMIT : cfg.index_bits;
		if (cfg.ways_in_use == '0)
			w = sac_pkg::CFG_W'(1);
		else if (cfg.ways_in_use > sac_pkg::WAYS_MAX)
			w = sac_pkg::WAYS_MAX;
		else
			w = cfg.ways_in_use;
		addr_sh   = in_item.address >> cfg.offset_bits;
		set_mask  = ~({(sac_pkg::SET_BITS+1){1'b1}} << ib);
		shift_tag = {1'b0, cfg.offset_bits} + {1'b0, ib};
		job_new.opcode  = in_item.opcode;
		job_new.set_idx = addr_sh[sac_pkg::SET_BITS-1:0] & set_mask[sac_pkg::SET_BITS-1:0];
		job_new.tag     = in_item.address >> shift_tag;
		job_new.ways    = w;
	end

	assign full = (cnt_q == 2'd2) || stat.clearing;
	assign acc  = push && !full;

	always_ff @(posedge clk) begin
		if (acc)
			q_q[wptr_q] <= job_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			if (acc)
				wptr_q <= ~wptr_q;
			if (stat.take)
				rptr_q <= ~rptr_q;
			cnt_q <= cnt_q + 2'(acc) - 2'(stat.take);
		end
	end

	assign req.valid = (cnt_q != '0);
	assign req.job   = q_q[rptr_q];

endmodule

// File: design/sac_back.sv
// Back end: set memory, hit/victim search, LRU and counter update, result queue.
// Runs a clearing pass over the set memory after reset. Depends on sac_pkg.
module sac_back (
	input  logic                clk,
	input  logic                arst_n,
	input  sac_pkg::job_req_t   req,
	output sac_pkg::back_stat_t stat,
	output logic                empty,
	input  logic                pop,
	output sac_pkg::out_item_t  out_item
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CMP  = 2'd1;
	localparam logic [1:0] ST_UPD  = 2'd2;

	sac_pkg::row_t mem [sac_pkg::NUM_SETS];

	logic [1:0]                      st_q;
	logic                            clr_q;
	logic [sac_pkg::SET_BITS-1:0]    clr_idx_q;
	sac_pkg::job_t                   job_q;
	sac_pkg::row_t                   row_q, row_new;
	logic                            hit_q, evict_q;
	logic [sac_pkg::WAY_BITS-1:0]    k_q;
	logic [sac_pkg::RANK_W-1:0]      old_rank_q;
	logic [sac_pkg::CNT_W-1:0]       rd_q, wr_q, rdm_q, wrm_q, cev_q, dev_q, cs_q;
	logic [sac_pkg::CNT_W-1:0]       rd_n, wr_n, rdm_n, wrm_n, cev_n, dev_n, cs_n;
	sac_pkg::out_item_t              of_q [2];
	logic                            owp_q, orp_q;
	logic [1:0]                      ocnt_q;
	logic                            start, upd, opop;

	// search results
	logic                            hit_c, emp_c;
	logic [sac_pkg::WAY_BITS-1:0]    hit_k, emp_k, vic_k;
	logic                            dirty_k;

	assign start = (st_q == ST_IDLE) && !clr_q && req.valid && (ocnt_q != 2'd2);
	assign upd   = (st_q == ST_UPD);
	assign opop  = pop && (ocnt_q != '0);

	assign stat.take     = start;
	assign stat.clearing = clr_q;

	always_ff @(posedge clk) begin
		if (clr_q)
			mem[clr_idx_q] <= '0;
		else if (upd)
			mem[job_q.set_idx] <= row_new;
		if (start)
			row_q <= mem[req.job.set_idx];
	end

	always_comb begin
		hit_c = 1'b0;
		hit_k = '0;
		emp_c = 1'b0;
		emp_k = '0;
		vic_k = '0;
		for (int j = 0; j < sac_pkg::MAX_WAYS; j++) begin
			if (sac_pkg::CFG_W'(j) < job_q.ways) begin
				if (!hit_c && row_q.valid[j] && row_q.tag[j] == job_q.tag) begin
					hit_c = 1'b1;
					hit_k = sac_pkg::WAY_BITS'(j);
				end
				if (!emp_c && !row_q.valid[j]) begin
					emp_c = 1'b1;
					emp_k = sac_pkg::WAY_BITS'(j);
				end
				if (row_q.rank[j] > row_q.rank[vic_k])
					vic_k = sac_pkg::WAY_BITS'(j);
			end
		end
	end

	assign dirty_k = row_q.dirty[k_q];

	always_comb begin
		row_new = row_q;
		if (hit_q) begin
			if (job_q.opcode == sac_pkg::OP_WRITE)
				row_new.dirty[k_q] = 1'b1;
		end else begin
			row_new.valid[k_q] = 1'b1;
			row_new.tag[k_q]   = job_q.tag;
			row_new.dirty[k_q] = job_q.opcode;
		end
		for (int j = 0; j < sac_pkg::MAX_WAYS; j++) begin
			if (sac_pkg::CFG_W'(j) < job_q.ways && sac_pkg::WAY_BITS'(j) != k_q &&
					row_q.valid[j] && row_q.rank[j] < old_rank_q)
				row_new.rank[j] = row_q.rank[j] + sac_pkg::RANK_W'(1);
		end
		row_new.rank[k_q] = '0;

		rd_n = rd_q; wr_n = wr_q; rdm_n = rdm_q; wrm_n = wrm_q;
		cev_n = cev_q; dev_n = dev_q; cs_n = cs_q;
		if (job_q.opcode == sac_pkg::OP_WRITE)
			wr_n = sac_pkg::sat_inc(wr_q);
		else
			rd_n = sac_pkg::sat_inc(rd_q);
		if (hit_q) begin
			if (job_q.opcode == sac_pkg::OP_WRITE && !dirty_k)
				cs_n = cs_q ^ sac_pkg::CNT_W'(1);
		end else begin
			if (job_q.opcode == sac_pkg::OP_WRITE)
				wrm_n = sac_pkg::sat_inc(wrm_q);
			else
				rdm_n = sac_pkg::sat_inc(rdm_q);
			if (evict_q) begin
				if (dirty_k)
					dev_n = sac_pkg::sat_inc(dev_q);
				else
					cev_n = sac_pkg::sat_inc(cev_q);
				cs_n = cs_n ^ sac_pkg::line_sum(row_q.tag[k_q], job_q.set_idx, dirty_k);
			end
			cs_n = cs_n ^ sac_pkg::line_sum(job_q.tag, job_q.set_idx, job_q.opcode);
		end
	end

	always_ff @(posedge clk) begin
		if (start)
			job_q <= req.job;
		if (st_q == ST_CMP) begin
			hit_q   <= hit_c;
			evict_q <= !hit_c && !emp_c;
			if (hit_c) begin
				k_q        <= hit_k;
				old_rank_q <= row_q.rank[hit_k];
			end else if (emp_c) begin
				k_q        <= emp_k;
				old_rank_q <= job_q.ways;
			end else begin
				k_q        <= vic_k;
				old_rank_q <= row_q.rank[vic_k];
			end
		end
		if (upd) begin
			of_q[owp_q].hit               <= hit_q;
			of_q[owp_q].evicted           <= evict_q;
			of_q[owp_q].evicted_dirty     <= evict_q && dirty_k;
			of_q[owp_q].read_count        <= rd_n;
			of_q[owp_q].write_count       <= wr_n;
			of_q[owp_q].read_miss_count   <= rdm_n;
			of_q[owp_q].write_miss_count  <= wrm_n;
			of_q[owp_q].clean_evict_count <= cev_n;
			of_q[owp_q].dirty_evict_count <= dev_n;
			of_q[owp_q].state_checksum    <= cs_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= ST_IDLE;
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
			rd_q <= '0; wr_q <= '0; rdm_q <= '0; wrm_q <= '0;
			cev_q <= '0; dev_q <= '0; cs_q <= '0;
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= '0;
		end else begin
			if (clr_q) begin
				clr_idx_q <= clr_idx_q + 1'b1;
				if (&clr_idx_q)
					clr_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: if (start) st_q <= ST_CMP;
				ST_CMP:  st_q <= ST_UPD;
				ST_UPD:  st_q <= ST_IDLE;
				default: st_q <= ST_IDLE;
			endcase
			if (upd) begin
				rd_q <= rd_n; wr_q <= wr_n; rdm_q <= rdm_n; wrm_q <= wrm_n;
				cev_q <= cev_n; dev_q <= dev_n; cs_q <= cs_n;
				owp_q <= ~owp_q;
			end
			if (opop)
				orp_q <= ~orp_q;
			ocnt_q <= ocnt_q + 2'(upd) - 2'(opop);
		end
	end

	assign empty    = (ocnt_q == '0);
	assign out_item = of_q[orp_q];

endmodule

// File: design/set_assoc_lru_cache_model.sv
// Set-associative write-back cache model with true LRU replacement.
// Accesses arrive on a queue-like input (push/full, in_item) and each gives
// one result on a queue-like output (empty/pop, out_item). Results come out
// in access order with the hit and eviction flags, six saturating counters
// and the running line checksum as they stand after that access.
// An access goes from the input queue through the back end's compare and update
// states to the result queue; no new access starts until the read-compare-write
// of one set row in the set memory is done. A 2-entry queue buffers accesses
// ahead of the back end and a 2-entry queue holds results, so the input keeps
// taking items while results wait; with pop held low the block stops after
// those queues fill. Reset (arst_n low) clears counters, checksum and queues
// and loads the geometry registers with 6 index bits, 5 offset bits and 4 ways.
// After reset a clearing pass over all 1024 sets empties the set memory; full
// stays high during it. Geometry registers sit on an APB port at 0x0, 0x4 and
// 0x8 and are to be changed by the user only while no access is in flight;
// the block does not enforce this. Depends on sac_pkg, sac_front and sac_back.
module set_assoc_lru_cache_model (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  sac_pkg::in_item_t  in_item,
	output logic               empty,
	input  logic               pop,
	output sac_pkg::out_item_t out_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam logic [1:0] REG_INDEX_BITS  = 2'd0;
	localparam logic [1:0] REG_OFFSET_BITS = 2'd1;
	localparam logic [1:0] REG_WAYS        = 2'd2;

	sac_pkg::cfg_t       cfg_q;
	sac_pkg::job_req_t   req;
	sac_pkg::back_stat_t stat;
	logic                wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.index_bits  <= sac_pkg::CFG_W'(6);
			cfg_q.offset_bits <= sac_pkg::CFG_W'(5);
			cfg_q.ways_in_use <= sac_pkg::CFG_W'(4);
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_INDEX_BITS:  cfg_q.index_bits  <= pwdata[sac_pkg::CFG_W-1:0];
				REG_OFFSET_BITS: cfg_q.offset_bits <= pwdata[sac_pkg::CFG_W-1:0];
				REG_WAYS:        cfg_q.ways_in_use <= pwdata[sac_pkg::CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_INDEX_BITS:  prdata = 32'(cfg_q.index_bits);
			REG_OFFSET_BITS: prdata = 32'(cfg_q.offset_bits);
			REG_WAYS:        prdata = 32'(cfg_q.ways_in_use);
			default:         prdata = '0;
		endcase
	end

	sac_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.in_item (in_item),
		.cfg     (cfg_q),
		.req     (req),
		.stat    (stat)
	);

	sac_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.stat     (stat),
		.empty    (empty),
		.pop      (pop),
		.out_item (out_item)
	);

endmodule

// File: design/sac_checker.sv
// Port-level checks for the cache model, bound to the top level.
// Depends on sac_pkg and set_assoc_lru_cache_model.
module sac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               empty,
	input logic               pop,
	input sac_pkg::out_item_t out_item
);

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> !(out_item.hit && out_item.evicted))
		else $error("hit result reports an eviction");

	a_dirty_needs_evict: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.evicted_dirty |-> out_item.evicted)
		else $error("dirty eviction flag without eviction");

	a_writes_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) ##1 !empty |->
			out_item.write_count >= $past(out_item.write_count))
		else $error("write count went backwards");

	a_miss_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> out_item.read_miss_count <= out_item.read_count)
		else $error("more read misses than reads");

endmodule

bind set_assoc_lru_cache_model sac_checker u_sac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.empty    (empty),
	.pop      (pop),
	.out_item (out_item)
);
